// ----- sv/rcnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root counter package
// Shared constants and types for the three-channel root counter: command
// codes, register offsets, mode word bit positions and the operation struct
// broadcast to the timers.
// ----------------------------------------------------------------------------
package rcnt_pkg;

    localparam int NUM_TIMERS = 3;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register offsets within one timer.
    localparam logic [3:0] REG_COUNT  = 4'd0;
    localparam logic [3:0] REG_MODE   = 4'd4;
    localparam logic [3:0] REG_TARGET = 4'd8;

    // Mode word bit positions.
    localparam int MODE_SYNC_EN     = 0;
    localparam int MODE_SYNC_LO     = 1;
    localparam int MODE_SYNC_HI     = 2;
    localparam int MODE_RESET_TGT   = 3;
    localparam int MODE_IRQ_TGT     = 4;
    localparam int MODE_IRQ_MAX     = 5;
    localparam int MODE_REPEAT      = 6;
    localparam int MODE_TOGGLE      = 7;
    localparam int MODE_CLK_HI      = 9;
    localparam int MODE_IRQ_NOT     = 10;
    localparam int MODE_REACHED_TGT = 11;
    localparam int MODE_REACHED_MAX = 12;

    // Prescale shift for timer 2 when it counts system cycles / 8.
    localparam int PRESCALE_SHIFT = 3;

    // One decoded operation, as seen by every timer.
    typedef struct packed {
        logic        tick;
        logic        rd;
        logic        wr;
        logic [3:0]  offset;
        logic [15:0] data;
        logic [15:0] cycles;
    } rcnt_op_t;

endpackage

// ----- sv/rcnt_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root counter timer
// One 16-bit timer with count, target and mode registers. Applies a tick,
// a register read or a register write when step is high, and reports the
// read data and whether the timer raised its interrupt.
// ----------------------------------------------------------------------------
module rcnt_timer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              sel,
    input  logic              prescale_capable,
    input  logic              sync_capable,
    input  rcnt_pkg::rcnt_op_t op,
    output logic [15:0]       rd_data,
    output logic              fired
);
    import rcnt_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] mode_reg, mode_next;
    logic        paused_reg, paused_next;
    logic        fired_reg, fired_next;

    logic [15:0] inc;
    logic [16:0] sum;
    logic [16:0] v_tgt;
    logic [16:0] v_max;
    logic [15:0] m_adv;
    logic        may_irq;
    logic        adv_fire;
    logic [1:0]  wr_sync_sel;

    // Increment: timer 2 may count system cycles divided by eight.
    assign inc = (prescale_capable && mode_reg[MODE_CLK_HI])
                 ? (op.cycles >> PRESCALE_SHIFT) : op.cycles;
    assign sum = {1'b0, count_reg} + {1'b0, inc};
    assign wr_sync_sel = op.data[MODE_SYNC_HI:MODE_SYNC_LO];

    // Tick advance: target and overflow events and the interrupt update.
    always_comb
    begin
        m_adv    = mode_reg;
        may_irq  = 1'b0;
        adv_fire = 1'b0;
        v_tgt    = sum;
        if (sum > {1'b0, target_reg})
        begin
            m_adv[MODE_REACHED_TGT] = 1'b1;
            if (mode_reg[MODE_IRQ_TGT])
            begin
                may_irq = 1'b1;
            end
            if (mode_reg[MODE_RESET_TGT])
            begin
                v_tgt = 17'd0;
            end
        end
        v_max = v_tgt;
        if (v_tgt[16])
        begin
            m_adv[MODE_REACHED_MAX] = 1'b1;
            if (mode_reg[MODE_IRQ_MAX])
            begin
                may_irq = 1'b1;
            end
            if (!mode_reg[MODE_RESET_TGT])
            begin
                v_max = 17'd0;
            end
        end
        if (may_irq)
        begin
            if (mode_reg[MODE_TOGGLE])
            begin
                m_adv[MODE_IRQ_NOT] = ~m_adv[MODE_IRQ_NOT];
            end
            else
            begin
                m_adv[MODE_IRQ_NOT] = 1'b0;
            end
            if (mode_reg[MODE_REPEAT] || !fired_reg)
            begin
                adv_fire = ~m_adv[MODE_IRQ_NOT];
                m_adv[MODE_IRQ_NOT] = 1'b1;
            end
        end
    end

    // Next state for the addressed register or the tick.
    always_comb
    begin
        count_next  = count_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        paused_next = paused_reg;
        fired_next  = fired_reg;
        rd_data     = 16'd0;
        fired       = 1'b0;
        if (op.tick && !paused_reg)
        begin
            count_next = v_max[15:0];
            mode_next  = m_adv;
            fired      = adv_fire;
            fired_next = fired_reg | adv_fire;
        end
        else if (op.rd && sel)
        begin
            case (op.offset)
                REG_COUNT:  rd_data = count_reg;
                REG_MODE:
                begin
                    rd_data = mode_reg;
                    mode_next[MODE_REACHED_TGT] = 1'b0;
                    mode_next[MODE_REACHED_MAX] = 1'b0;
                end
                REG_TARGET: rd_data = target_reg;
                default:    rd_data = 16'd0;
            endcase
        end
        else if (op.wr && sel)
        begin
            case (op.offset)
                REG_COUNT:  count_next = op.data;
                REG_MODE:
                begin
                    mode_next = op.data;
                    mode_next[MODE_IRQ_NOT] = 1'b1;
                    count_next  = 16'd0;
                    fired_next  = 1'b0;
                    paused_next = sync_capable && op.data[MODE_SYNC_EN]
                                  && (wr_sync_sel == 2'd0 || wr_sync_sel == 2'd3);
                end
                REG_TARGET: target_next = op.data;
                default:    count_next = count_reg;
            endcase
        end
    end

    // Timer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 16'd0;
            target_reg <= 16'd0;
            mode_reg   <= 16'd0;
            paused_reg <= 1'b0;
            fired_reg  <= 1'b0;
        end
        else if (step)
        begin
            count_reg  <= count_next;
            target_reg <= target_next;
            mode_reg   <= mode_next;
            paused_reg <= paused_next;
            fired_reg  <= fired_next;
        end
    end

endmodule

// ----- sv/three_channel_root_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-channel root counter
// Three 16-bit timers driven by tick, register read and register write
// transactions on one input channel, with one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries command, timer_index,
// reg_offset, write_data and tick_cycles. A tick adds tick_cycles, or for
// timer 2 possibly tick_cycles / 8, to every running timer; a read returns
// the addressed register on read_data; a write updates the addressed
// register. Every transaction yields exactly one result on out_valid /
// out_stall with read_data and irq_pulse. The transaction is captured in
// the input register at the accepting edge, processed by the timers and
// loaded into the result register once that is free, where out_valid rises.
// Throughput is one transaction per cycle unless the receiver stalls; the
// timer update is a single add and compare per timer between the two
// registers. On a receiver stall the result register holds, an empty input
// register still takes one more transaction, and then in_stall rises until
// the result is taken. Reset clears all timer registers and both stages.
// ----------------------------------------------------------------------------
module three_channel_root_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  timer_index,
    input  logic [3:0]  reg_offset,
    input  logic [15:0] write_data,
    input  logic [15:0] tick_cycles,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic [2:0]  irq_pulse
);
    import rcnt_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  idx_reg;
    logic [3:0]  offset_reg;
    logic [15:0] data_reg;
    logic [15:0] cycles_reg;

    logic        out_valid_reg;
    logic [15:0] read_data_reg, read_data_next;
    logic [2:0]  irq_reg, irq_next;

    logic        out_free;
    logic        step;
    rcnt_op_t    op;
    logic [15:0] rd_lane [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] fire_lane;

    // Pipeline flow control.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg    <= command;
            idx_reg    <= timer_index;
            offset_reg <= reg_offset;
            data_reg   <= write_data;
            cycles_reg <= tick_cycles;
        end
    end

    // Operation decode shared by all timers.
    always_comb
    begin
        op.tick   = (cmd_reg == CMD_TICK);
        op.rd     = (cmd_reg == CMD_READ);
        op.wr     = (cmd_reg == CMD_WRITE);
        op.offset = offset_reg;
        op.data   = data_reg;
        op.cycles = cycles_reg;
    end

    // The three timers; only timer 2 has prescale and sync pause.
    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_timer
        rcnt_timer u_timer (
            .clk              (clk),
            .rst_n            (rst_n),
            .step             (step),
            .sel              (idx_reg == 2'(i)),
            .prescale_capable (i == 2),
            .sync_capable     (i == 2),
            .op               (op),
            .rd_data          (rd_lane[i]),
            .fired            (fire_lane[i])
        );
    end

    // Merge the timer results; unselected timers return zero.
    always_comb
    begin
        read_data_next = 16'd0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            read_data_next = read_data_next | rd_lane[i];
        end
        irq_next = fire_lane;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_pulse = irq_reg;

    // The input stage only stalls behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stall without a held result");

    // A result carries read data or interrupts, never both.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_data == 16'd0 || irq_pulse == 3'd0))
        else $error("result has both read data and interrupts");

    // A taken result with nothing pending leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !in_valid_reg) |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule
